/* rtl/cst_pkg.sv */
//------------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and constants of the CBOR stream tokenizer.
//------------------------------------------------------------------------------
`default_nettype none
package cst_pkg;

    localparam int unsigned MaxDepthDefault   = 8;
    localparam int unsigned CountWidthDefault = 32;
    localparam logic [15:0] MaxLengthReset    = 16'd4096;
    localparam logic [63:0] NegTop            = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        EV_HEAD  = 2'd0,
        EV_BYTE  = 2'd1,
        EV_EOS   = 2'd2,
        EV_ERROR = 2'd3
    } event_t;

    typedef enum logic [3:0] {
        IT_UINT   = 4'd0,
        IT_NEGINT = 4'd1,
        IT_BYTES  = 4'd2,
        IT_TEXT   = 4'd3,
        IT_ARRAY  = 4'd4,
        IT_MAP    = 4'd5,
        IT_FALSE  = 4'd6,
        IT_TRUE   = 4'd7,
        IT_NULL   = 4'd8,
        IT_BREAK  = 4'd9
    } item_type_t;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_UNSUPPORTED = 4'd1,
        ERR_BAD_INFO    = 4'd2,
        ERR_STRAY_BREAK = 4'd3,
        ERR_TOO_DEEP    = 4'd4,
        ERR_NEG_RANGE   = 4'd5,
        ERR_BAD_KEY     = 4'd6,
        ERR_KEY_LONG    = 4'd7,
        ERR_ARRAY_ELEM  = 4'd8,
        ERR_FOREIGN     = 4'd9,
        ERR_EARLY_END   = 4'd10
    } err_t;

    typedef enum logic [1:0] {
        PH_HEAD   = 2'd0,
        PH_ARG    = 2'd1,
        PH_STRING = 2'd2
    } phase_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  item_type;
        logic [63:0] argument;
        logic        indefinite;
        logic        is_key;
        logic [7:0]  payload_byte;
        logic        chunk_end;
        logic        string_last;
        logic [3:0]  depth;
        logic [3:0]  error_code;
    } out_beat_t;

endpackage
`default_nettype wire

/* rtl/cbor_stream_tokenizer_unit.sv */
//------------------------------------------------------------------------------
// cbor_stream_tokenizer_unit
// Streaming CBOR tokenizer: one stream byte per beat in, one event per beat out.
//------------------------------------------------------------------------------
// Channel   Direction  Handshake           Beat contents
// s_        in         s_valid / s_ready   in_beat_t: op, data_byte
// m_        out        m_valid / m_ready   out_beat_t: event fields
// cfg       in         cfg_we              max_length (16 bit)
//
// One input beat is taken per cycle; its event, if any, is registered in a
// two-entry output buffer and is presented after any beats ahead of it. The
// combinational path is the decode step in cst_core plus the stack update.
// Reset is synchronous and active low and brings max_length back to 4096.
// The input stalls only while both output buffer entries are full.
//------------------------------------------------------------------------------
`default_nettype none
module cbor_stream_tokenizer_unit
    import cst_pkg::*;
#(
    parameter int unsigned MAX_DEPTH   = MaxDepthDefault,
    parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data
);

    logic [15:0] max_length_reg;
    logic        ev_valid;
    out_beat_t   ev_beat;
    logic        step;

    // Two-entry buffer: entry 0 is the presented beat, entry 1 the skid slot.
    out_beat_t   buf_reg [2];
    logic [1:0]  cnt_reg;

    assign s_ready = (cnt_reg != 2'd2);
    assign step    = s_valid && s_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = buf_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) max_length_reg <= MaxLengthReset;
        else if (cfg_we) max_length_reg <= cfg_wdata;
    end

    cst_core #(.MAX_DEPTH(MAX_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_length (max_length_reg),
        .step       (step),
        .in_beat    (s_data),
        .ev_valid   (ev_valid),
        .ev_beat    (ev_beat)
    );

    logic pop, push;
    assign pop  = m_valid && m_ready;
    assign push = ev_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // A full buffer never takes a new event, so a pop from two entries only
    // shifts the skid slot forward.
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (cnt_reg == 2'd2) buf_reg[0] <= buf_reg[1];
            else if (push) buf_reg[0] <= ev_beat;
        end else if (push) begin
            if (cnt_reg == 2'd0) buf_reg[0] <= ev_beat;
            else buf_reg[1] <= ev_beat;
        end
    end

    property p_no_overflow;
        @(posedge aclk) disable iff (!aresetn) cnt_reg == 2'd2 |-> !ev_valid;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("output buffer overflow");

    property p_cnt_range;
        @(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3;
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("buffer count out of range");

    property p_hold;
        @(posedge aclk) disable iff (!aresetn) m_valid && !m_ready |=> m_valid;
    endproperty
    a_hold: assert property (p_hold) else $error("output dropped while stalled");

endmodule
`default_nettype wire

/* rtl/cst_core.sv */
//------------------------------------------------------------------------------
// cst_core
// Parser state and one-byte decode step; produces at most one event a beat.
//------------------------------------------------------------------------------
`default_nettype none
module cst_core
    import cst_pkg::*;
#(
    parameter int unsigned MAX_DEPTH   = MaxDepthDefault,
    parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] max_length,
    input  wire logic        step,
    input  wire in_beat_t    in_beat,
    output logic             ev_valid,
    output out_beat_t        ev_beat
);

    localparam int unsigned PtrW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned IdxW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   is_map;
        logic                   indef;
        logic                   want_value;
    } level_t;

    // Stack entries are read only below the pointer, so no reset is needed.
    level_t   stack_reg [MAX_DEPTH];
    level_t   top_next_w;
    logic     top_wr;
    level_t   push_w;
    logic     push_wr;

    phase_t        phase_reg, phase_next;
    logic [3:0]    left_reg, left_next;
    logic [63:0]   acc_reg, acc_next;
    logic [8:0]    pend_reg, pend_next;
    logic [63:0]   rem_reg, rem_next;
    logic [15:0]   chunk_reg, chunk_next;
    logic [1:0]    istr_reg, istr_next;
    logic [PtrW-1:0] ptr_reg, ptr_next;
    logic          err_reg, err_next;

    // Done marks: level i is complete (definite, count 0, not awaiting a value).
    logic [MAX_DEPTH-1:0] done_w;
    always_comb begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
            done_w[i] = !stack_reg[i].indef && (stack_reg[i].count == '0)
                        && !stack_reg[i].want_value;
        end
    end

    // New pointer after the top is updated: lower levels keep their done marks;
    // the top and a pushed level use new ones. Pops run from the top while done.
    function automatic logic [PtrW-1:0] close_ptr(input logic [PtrW-1:0] p,
                                                  input logic [MAX_DEPTH-1:0] dm);
        logic [PtrW-1:0] r;
        logic            go;
        r  = p;
        go = 1'b1;
        for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
            if (go && (PtrW'(i) < p)) begin
                if (dm[i]) r = PtrW'(i);
                else go = 1'b0;
            end
        end
        return r;
    endfunction

    logic [IdxW-1:0] top_idx;
    level_t          top_w;
    logic            have_top;
    assign have_top = (ptr_reg != '0);
    assign top_idx  = IdxW'(ptr_reg - 1'b1);
    assign top_w    = have_top ? stack_reg[top_idx] : '0;

    always_comb begin
        logic [2:0]  major;
        logic [4:0]  info;
        logic [7:0]  hb;
        logic [63:0] arg;
        logic        indef;
        logic [3:0]  ty;
        logic        key;
        logic        do_head;
        logic        fail;
        logic [3:0]  code;
        logic [MAX_DEPTH-1:0] dm;
        logic [PtrW-1:0] pc;
        logic        want_close;
        logic        seg_end;
        logic [63:0] rem_dec;
        logic [15:0] cc;
        level_t      nt;

        phase_next = phase_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        istr_next  = istr_reg;
        ptr_next   = ptr_reg;
        err_next   = err_reg;
        top_wr     = 1'b0;
        top_next_w = top_w;
        push_wr    = 1'b0;
        push_w     = '0;
        ev_valid   = 1'b0;
        ev_beat    = '0;
        ev_beat.depth = 4'(ptr_reg);

        major = in_beat.data_byte[7:5];
        info  = in_beat.data_byte[4:0];
        hb    = in_beat.data_byte;
        arg   = '0;
        do_head = 1'b0;
        fail  = 1'b0;
        code  = ERR_NONE;
        want_close = 1'b0;
        nt    = top_w;
        key   = 1'b0;
        ty    = IT_UINT;
        indef = 1'b0;
        seg_end = 1'b0;
        rem_dec = '0;
        cc    = '0;
        dm    = '0;
        pc    = '0;

        if (step && !err_reg) begin
            if (in_beat.op) begin
                if (phase_reg == PH_HEAD && ptr_reg == '0 && istr_reg == 2'd0) begin
                    ev_valid = 1'b1;
                    ev_beat.event_res = EV_EOS;
                end else begin
                    fail = 1'b1;
                    code = ERR_EARLY_END;
                end
            end else begin
                unique case (phase_reg)
                    PH_ARG: begin
                        acc_next  = {acc_reg[55:0], in_beat.data_byte};
                        left_next = left_reg - 4'd1;
                        if (left_reg == 4'd1) begin
                            phase_next = PH_HEAD;
                            do_head    = 1'b1;
                            hb         = pend_reg[7:0];
                            arg        = acc_next;
                        end
                    end
                    PH_STRING: begin
                        rem_dec  = rem_reg - 64'd1;
                        rem_next = rem_dec;
                        cc       = chunk_reg + 16'd1;
                        seg_end  = (rem_dec == '0);
                        ev_valid = 1'b1;
                        ev_beat.event_res    = EV_BYTE;
                        ev_beat.item_type    = {1'b0, pend_reg[7:5]};
                        ev_beat.is_key       = pend_reg[8];
                        ev_beat.payload_byte = in_beat.data_byte;
                        ev_beat.chunk_end    = seg_end
                                               || (max_length != '0 && cc == max_length);
                        ev_beat.string_last  = seg_end && istr_reg == 2'd0;
                        chunk_next = ev_beat.chunk_end ? 16'd0 : cc;
                        if (seg_end) begin
                            phase_next = PH_HEAD;
                            want_close = (istr_reg == 2'd0);
                        end
                    end
                    default: begin
                        if (info >= 5'd28 && info <= 5'd30) begin
                            fail = 1'b1; code = ERR_BAD_INFO;
                        end else if (major == 3'd6) begin
                            fail = 1'b1; code = ERR_UNSUPPORTED;
                        end else if (major == 3'd7 && info != 5'd20 && info != 5'd21
                                     && info != 5'd22 && info != 5'd31) begin
                            fail = 1'b1; code = ERR_UNSUPPORTED;
                        end else if (major <= 3'd1 && info == 5'd31) begin
                            fail = 1'b1; code = ERR_BAD_INFO;
                        end else begin
                            pend_next = {1'b0, hb};
                            if (info >= 5'd24 && info <= 5'd27) begin
                                phase_next = PH_ARG;
                                left_next  = 4'd1 << info[1:0];
                                acc_next   = '0;
                            end else begin
                                do_head = 1'b1;
                                arg = (major != 3'd7 && info <= 5'd23) ? 64'(info) : 64'd0;
                            end
                        end
                    end
                endcase
            end

            if (do_head) begin
                major = hb[7:5];
                info  = hb[4:0];
                indef = (info == 5'd31);
                if (major <= 3'd5)      ty = {1'b0, major};
                else if (info == 5'd20) ty = IT_FALSE;
                else if (info == 5'd21) ty = IT_TRUE;
                else if (info == 5'd22) ty = IT_NULL;
                else                    ty = IT_BREAK;

                if (istr_reg != 2'd0) begin
                    if (ty == IT_BREAK) begin
                        istr_next = 2'd0;
                        ev_valid = 1'b1;
                        ev_beat.item_type   = IT_BREAK;
                        ev_beat.indefinite  = 1'b1;
                        ev_beat.string_last = 1'b1;
                        want_close = 1'b1;
                    end else if (ty != {2'b00, istr_reg} || indef) begin
                        fail = 1'b1; code = ERR_FOREIGN;
                    end else begin
                        ev_valid = 1'b1;
                        ev_beat.item_type = ty;
                        ev_beat.argument  = arg;
                        if (arg != '0) begin
                            pend_next  = {1'b0, hb};
                            rem_next   = arg;
                            chunk_next = '0;
                            phase_next = PH_STRING;
                        end
                    end
                end else if (ty == IT_BREAK) begin
                    if (have_top && top_w.indef && (!top_w.is_map || !top_w.want_value)) begin
                        ptr_next = ptr_reg - 1'b1;
                        ev_valid = 1'b1;
                        ev_beat.item_type  = IT_BREAK;
                        ev_beat.indefinite = 1'b1;
                        ev_beat.depth      = 4'(ptr_next);
                        want_close = 1'b1;
                    end else begin
                        fail = 1'b1; code = ERR_STRAY_BREAK;
                    end
                end else begin
                    key = have_top && top_w.is_map && !top_w.want_value;
                    if (key) begin
                        if (ty == IT_NEGINT) begin
                            if (arg >= NegTop) begin fail = 1'b1; code = ERR_NEG_RANGE; end
                        end else if (ty == IT_BYTES || ty == IT_TEXT) begin
                            if (indef) begin
                                fail = 1'b1; code = ERR_BAD_KEY;
                            end else if (arg > 64'(max_length)) begin
                                fail = 1'b1; code = ERR_KEY_LONG;
                            end
                        end else if (ty != IT_UINT) begin
                            fail = 1'b1; code = ERR_BAD_KEY;
                        end
                    end else if (have_top && !top_w.is_map) begin
                        if (ty != IT_BYTES) begin fail = 1'b1; code = ERR_ARRAY_ELEM; end
                    end else if (ty == IT_NEGINT && arg > NegTop) begin
                        fail = 1'b1; code = ERR_NEG_RANGE;
                    end

                    if (!fail && (ty == IT_ARRAY || ty == IT_MAP)) begin
                        if (!indef && (arg >> COUNT_WIDTH) != '0) begin
                            fail = 1'b1; code = ERR_TOO_DEEP;
                        end else if (ptr_reg >= PtrW'(MAX_DEPTH)) begin
                            fail = 1'b1; code = ERR_TOO_DEEP;
                        end
                    end

                    if (!fail) begin
                        if (have_top) begin
                            top_wr = 1'b1;
                            if (top_w.is_map) begin
                                if (!top_w.want_value) begin
                                    nt.want_value = 1'b1;
                                end else begin
                                    nt.want_value = 1'b0;
                                    if (!top_w.indef && top_w.count != '0)
                                        nt.count = top_w.count - 1'b1;
                                end
                            end else if (!top_w.indef && top_w.count != '0) begin
                                nt.count = top_w.count - 1'b1;
                            end
                            top_next_w = nt;
                        end
                        ev_valid = 1'b1;
                        ev_beat.item_type = ty;
                        ev_beat.is_key    = key;
                        if (ty == IT_BYTES || ty == IT_TEXT) begin
                            if (indef) begin
                                ev_beat.indefinite = 1'b1;
                                istr_next = ty[1:0];
                            end else if (arg == '0) begin
                                ev_beat.string_last = 1'b1;
                                want_close = 1'b1;
                            end else begin
                                ev_beat.argument = arg;
                                pend_next  = {key, hb};
                                rem_next   = arg;
                                chunk_next = '0;
                                phase_next = PH_STRING;
                            end
                        end else begin
                            ev_beat.argument   = arg;
                            ev_beat.indefinite = indef;
                            want_close = 1'b1;
                            if (ty == IT_ARRAY || ty == IT_MAP) begin
                                push_wr = 1'b1;
                                push_w.count      = indef ? '0 : COUNT_WIDTH'(arg);
                                push_w.is_map     = (ty == IT_MAP);
                                push_w.indef      = indef;
                                push_w.want_value = 1'b0;
                                ptr_next = ptr_reg + 1'b1;
                            end
                        end
                    end
                end
            end

            if (fail) begin
                err_next = 1'b1;
                ev_valid = 1'b1;
                ev_beat  = '0;
                ev_beat.event_res  = EV_ERROR;
                ev_beat.depth      = 4'(ptr_reg);
                ev_beat.error_code = code;
                top_wr  = 1'b0;
                push_wr = 1'b0;
                ptr_next = ptr_reg;
                want_close = 1'b0;
            end

            if (want_close) begin
                dm = done_w;
                if (top_wr) dm[top_idx] = !nt.indef && nt.count == '0 && !nt.want_value;
                if (push_wr) begin
                    dm[IdxW'(ptr_reg)] = !push_w.indef && push_w.count == '0;
                end
                pc = close_ptr(ptr_next, dm);
                ptr_next = pc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (top_wr) stack_reg[top_idx] <= top_next_w;
        if (push_wr) stack_reg[IdxW'(ptr_reg)] <= push_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEAD;
            left_reg  <= '0;
            acc_reg   <= '0;
            pend_reg  <= '0;
            rem_reg   <= '0;
            chunk_reg <= '0;
            istr_reg  <= '0;
            ptr_reg   <= '0;
            err_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            rem_reg   <= rem_next;
            chunk_reg <= chunk_next;
            istr_reg  <= istr_next;
            ptr_reg   <= ptr_next;
            err_reg   <= err_next;
        end
    end

    property p_ptr_bound;
        @(posedge aclk) disable iff (!aresetn) ptr_reg <= PtrW'(MAX_DEPTH);
    endproperty
    a_ptr_bound: assert property (p_ptr_bound) else $error("stack pointer overflow");

    property p_err_sticky;
        @(posedge aclk) disable iff (!aresetn) err_reg |=> err_reg;
    endproperty
    a_err_sticky: assert property (p_err_sticky) else $error("error flag cleared");

    property p_silent_after_err;
        @(posedge aclk) disable iff (!aresetn) err_reg |-> !ev_valid;
    endproperty
    a_silent_after_err: assert property (p_silent_after_err) else $error("event after error");

endmodule
`default_nettype wire
